// ===== hw/rtl/bpf_pkg.sv =====
`timescale 1ns / 1ps
// Byte pipe FIFO: shared types, widths, action and status codes, pointer helpers.
// No dependencies.
package bpf_pkg;

   localparam int unsigned DEPTH   = 512;
   localparam int unsigned PTR_MOD = 2 * DEPTH;
   localparam int unsigned PTR_W   = $clog2(PTR_MOD);
   localparam int unsigned ADDR_W  = $clog2(DEPTH);
   localparam int unsigned FILL_W  = 10;

   typedef logic [2:0]        action_type;
   typedef logic [2:0]        status_type;
   typedef logic [7:0]        byte_type;
   typedef logic [FILL_W-1:0] fill_type;
   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [ADDR_W-1:0] addr_type;

   localparam action_type ACT_WRITE   = 3'd0;
   localparam action_type ACT_READ    = 3'd1;
   localparam action_type ACT_CLOSE_W = 3'd2;
   localparam action_type ACT_CLOSE_R = 3'd3;
   localparam action_type ACT_OPEN    = 3'd4;

   localparam status_type ST_OK            = 3'd0;
   localparam status_type ST_WOULD_BLOCK   = 3'd1;
   localparam status_type ST_END_OF_STREAM = 3'd2;
   localparam status_type ST_KILLED        = 3'd3;
   localparam status_type ST_BROKEN_PIPE   = 3'd4;
   localparam status_type ST_PIPE_CLOSED   = 3'd5;

   typedef struct packed {
      logic accept;    // item taken this cycle: update pointers and flags
      logic load_imm;  // load result register from the item's immediate result
      logic load_rd;   // load result register from held fields and RAM data
   } cmd_type;

   typedef struct packed {
      logic rd_hit;    // presented item is a read that takes a byte
   } sts_type;

   // pointers wrap modulo 2*DEPTH
   function automatic ptr_type ptr_next(input ptr_type p);
      ptr_type r;
      if (p == PTR_W'(PTR_MOD - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   function automatic addr_type addr_of(input ptr_type p);
      ptr_type t;
      if (p >= PTR_W'(DEPTH)) begin
         t = p - PTR_W'(DEPTH);
      end else begin
         t = p;
      end
      return t[ADDR_W-1:0];
   endfunction

   function automatic ptr_type fill_of(input ptr_type wp, input ptr_type rp);
      logic [31:0] f;
      if (wp >= rp) begin
         f = 32'(wp) - 32'(rp);
      end else begin
         f = 32'(PTR_MOD) + 32'(wp) - 32'(rp);
      end
      return f[PTR_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/bpf_ram.sv =====
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bpf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bpf_ctrl.sv =====
`timescale 1ns / 1ps
// Byte pipe FIFO controller: handshakes, result register valid, read wait state.
// Depends on bpf_pkg.
module bpf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  bpf_pkg::sts_type sts,
   output bpf_pkg::cmd_type cmd
);
   import bpf_pkg::*;

   localparam logic S_IDLE   = 1'b0;
   localparam logic S_RDWAIT = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.accept = 1'b1;
               if (sts.rd_hit) begin
                  state_in = S_RDWAIT;
               end else begin
                  cmd.load_imm = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_RDWAIT: begin
            if (out_free) begin
               cmd.load_rd  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_rd_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && sts.rd_hit |=> state_ff == S_RDWAIT)
      else $error("read hit did not enter wait state");
   a_load_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_imm && cmd.load_rd))
      else $error("two result loads in one cycle");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !cmd.load_imm && !cmd.load_rd)
      else $error("pending result overwritten");
`endif

endmodule

// ===== hw/rtl/bpf_dp.sv =====
`timescale 1ns / 1ps
// Byte pipe FIFO datapath: pointers, end flags, byte store, result registers.
// Depends on bpf_pkg and bpf_ram.
module bpf_dp (
   input  logic                clock,
   input  logic                reset,
   input  bpf_pkg::cmd_type    cmd,
   output bpf_pkg::sts_type    sts,
   input  bpf_pkg::action_type req_action,
   input  bpf_pkg::byte_type   req_write_byte,
   input  logic                req_caller_killed,
   input  logic                req_last_of_request,
   output bpf_pkg::status_type rsp_status,
   output bpf_pkg::byte_type   rsp_read_byte,
   output logic                rsp_request_done,
   output bpf_pkg::fill_type   rsp_fill_level,
   output logic                rsp_read_end_open,
   output logic                rsp_write_end_open
);
   import bpf_pkg::*;

   ptr_type    wp_ff, wp_in, rp_ff, rp_in;
   logic       ropen_ff, ropen_in, wopen_ff, wopen_in;
   ptr_type    fill_now, fill_next;
   logic [31:0] fill_ext;
   status_type status_c;
   logic       done_c, wr_en, rd_en;
   byte_type   ram_rd_data;

   status_type status_ff, pend_status_ff;
   byte_type   rbyte_ff;
   logic       done_ff, pend_done_ff;
   fill_type   fill_ff, pend_fill_ff;
   logic       ropen_out_ff, pend_ropen_ff, wopen_out_ff, pend_wopen_ff;

   assign fill_now = fill_of(wp_ff, rp_ff);

   always_comb begin
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      ropen_in = ropen_ff;
      wopen_in = wopen_ff;
      status_c = ST_OK;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      case (req_action)
         ACT_WRITE: begin
            if (!wopen_ff) begin
               status_c = ST_PIPE_CLOSED;
            end else if (fill_now >= PTR_W'(DEPTH)) begin
               if (!ropen_ff) begin
                  status_c = ST_BROKEN_PIPE;
               end else if (req_caller_killed) begin
                  status_c = ST_KILLED;
               end else begin
                  status_c = ST_WOULD_BLOCK;
               end
            end else begin
               wr_en = 1'b1;
               wp_in = ptr_next(wp_ff);
            end
         end
         ACT_READ: begin
            if (!ropen_ff) begin
               status_c = ST_PIPE_CLOSED;
            end else if (fill_now == '0) begin
               if (!wopen_ff) begin
                  status_c = ST_END_OF_STREAM;
               end else if (req_caller_killed) begin
                  status_c = ST_KILLED;
               end else begin
                  status_c = ST_WOULD_BLOCK;
               end
            end else begin
               rd_en = 1'b1;
               rp_in = ptr_next(rp_ff);
            end
         end
         ACT_CLOSE_W, ACT_CLOSE_R: begin
            if (!ropen_ff && !wopen_ff) begin
               status_c = ST_PIPE_CLOSED;
            end else begin
               if (req_action == ACT_CLOSE_W) begin
                  wopen_in = 1'b0;
               end else begin
                  ropen_in = 1'b0;
               end
               if (!ropen_in && !wopen_in) begin
                  wp_in = '0;
                  rp_in = '0;
               end
            end
         end
         ACT_OPEN: begin
            wp_in    = '0;
            rp_in    = '0;
            ropen_in = 1'b1;
            wopen_in = 1'b1;
         end
         default: begin
         end
      endcase
      fill_next = fill_of(wp_in, rp_in);
      fill_ext  = 32'(fill_next);
      done_c    = (status_c == ST_OK && req_last_of_request) ||
                  (status_c inside {[ST_END_OF_STREAM:ST_PIPE_CLOSED]});
   end

   assign sts.rd_hit = rd_en;

   bpf_ram #(
      .WIDTH ($bits(byte_type)),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en && cmd.accept),
      .wr_addr (addr_of(wp_ff)),
      .wr_data (req_write_byte),
      .rd_en   (rd_en && cmd.accept),
      .rd_addr (addr_of(rp_ff)),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         ropen_ff <= 1'b1;
         wopen_ff <= 1'b1;
      end else if (cmd.accept) begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         ropen_ff <= ropen_in;
         wopen_ff <= wopen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pend_status_ff <= status_c;
         pend_done_ff   <= done_c;
         pend_fill_ff   <= fill_ext[FILL_W-1:0];
         pend_ropen_ff  <= ropen_in;
         pend_wopen_ff  <= wopen_in;
      end
      if (cmd.load_imm) begin
         status_ff    <= status_c;
         rbyte_ff     <= '0;
         done_ff      <= done_c;
         fill_ff      <= fill_ext[FILL_W-1:0];
         ropen_out_ff <= ropen_in;
         wopen_out_ff <= wopen_in;
      end else if (cmd.load_rd) begin
         status_ff    <= pend_status_ff;
         rbyte_ff     <= ram_rd_data;
         done_ff      <= pend_done_ff;
         fill_ff      <= pend_fill_ff;
         ropen_out_ff <= pend_ropen_ff;
         wopen_out_ff <= pend_wopen_ff;
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_read_byte      = rbyte_ff;
   assign rsp_request_done   = done_ff;
   assign rsp_fill_level     = fill_ff;
   assign rsp_read_end_open  = ropen_out_ff;
   assign rsp_write_end_open = wopen_out_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_now <= PTR_W'(DEPTH))
      else $error("fill above depth");
   a_freed_ptrs: assert property (@(posedge clock) disable iff (reset)
      !ropen_ff && !wopen_ff |-> wp_ff == '0 && rp_ff == '0)
      else $error("freed pipe with live pointers");
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.accept) && !$past(reset) |-> $stable(wp_ff) && $stable(rp_ff))
      else $error("pointer moved without an item");
`endif

endmodule

// ===== hw/rtl/byte_pipe_fifo_unit.sv =====
`timescale 1ns / 1ps
// Byte pipe FIFO top level: controller plus datapath.
// Depends on bpf_pkg, bpf_ctrl, bpf_dp.
//
//   channel   handshake              payload
//   req       req_valid/req_ready    action, write_byte, caller_killed, last_of_request
//   rsp       rsp_valid/rsp_ready    status, read_byte, request_done, fill_level,
//                                    read_end_open, write_end_open
//
// One item a cycle while no result is stalled, except a read that takes a byte: it adds a
// wait state, set by the registered read port of the byte store.
// An item is taken while the previous result waits, if that result leaves the same cycle.
// Reset is synchronous: pointers zero, both ends open, no result pending. Store not cleared.
// A stalled result holds req_ready low until rsp_ready.
module byte_pipe_fifo_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bpf_pkg::action_type req_action,
   input  bpf_pkg::byte_type   req_write_byte,
   input  logic                req_caller_killed,
   input  logic                req_last_of_request,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bpf_pkg::status_type rsp_status,
   output bpf_pkg::byte_type   rsp_read_byte,
   output logic                rsp_request_done,
   output bpf_pkg::fill_type   rsp_fill_level,
   output logic                rsp_read_end_open,
   output logic                rsp_write_end_open
);
   import bpf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bpf_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_action          (req_action),
      .req_write_byte      (req_write_byte),
      .req_caller_killed   (req_caller_killed),
      .req_last_of_request (req_last_of_request),
      .rsp_status          (rsp_status),
      .rsp_read_byte       (rsp_read_byte),
      .rsp_request_done    (rsp_request_done),
      .rsp_fill_level      (rsp_fill_level),
      .rsp_read_end_open   (rsp_read_end_open),
      .rsp_write_end_open  (rsp_write_end_open)
   );

endmodule
